// ===== src/tpad_pkg.sv =====
// ---------------------------------------------------------------------------
// Phase-angle dimmer package
// Shared widths, constants, codes and types for the phase-angle triac dimmer.
// ---------------------------------------------------------------------------
package tpad_pkg;

    // Field widths
    localparam int TS_BITS       = 32;
    localparam int HALF_BITS     = 32;
    localparam int FIRE_BITS     = 14;
    localparam int TICK_BITS     = 8;
    localparam int DIM_BITS      = 7;
    localparam int MIN_ZC_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 48;

    // Timing constants of the half cycle
    localparam logic [TICK_BITS-1:0]   CUTOFF_TICK     = 8'd175;
    localparam logic [TICK_BITS-1:0]   PULSE_TICKS     = 8'd5;
    localparam logic [TICK_BITS-1:0]   FIRE_BASE_TICK  = 8'd175;
    localparam logic [TICK_BITS-1:0]   FIRE_TICK_MAX   = 8'd199;
    localparam logic [TICK_BITS-1:0]   TICK_HARD_LIMIT = 8'd200;
    localparam logic [FIRE_BITS-1:0]   TICK_US         = 14'd50;
    localparam logic [MIN_ZC_BITS-1:0] MIN_ZC_RESET    = 16'd8000;

    // Item kinds carried on the input user signal
    localparam logic REQ_ZERO_CROSS = 1'b0;
    localparam logic REQ_TICK       = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_LEVEL = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_ZC    = 1'b1;

    // Per half-cycle state of the dimmer
    typedef struct packed {
        logic [TS_BITS-1:0]   last_crossing_time;
        logic [HALF_BITS-1:0] measured_half_cycle;
        logic [TICK_BITS-1:0] tick_count;
        logic                 armed;
        logic                 gate_level;
        logic [FIRE_BITS-1:0] last_fire_time;
    } state_t;

    // One result word, before packing onto the output bus
    typedef struct packed {
        logic [FIRE_BITS-1:0] fire_time_us;
        logic [HALF_BITS-1:0] half_cycle_us;
        logic                 zc_accepted;
        logic                 gate_on;
    } result_t;

    // Tick at which the gate fires for a given brightness, clamped to the maximum.
    function automatic logic [TICK_BITS-1:0] gate_tick(input logic [DIM_BITS-1:0] dim);
        logic [TICK_BITS-1:0] half;
        logic [TICK_BITS-1:0] ft;
        half = TICK_BITS'(dim >> 1);
        if (half > FIRE_BASE_TICK) begin
            ft = FIRE_TICK_MAX;
        end else begin
            ft = FIRE_BASE_TICK - half;
            if (ft > FIRE_TICK_MAX) begin
                ft = FIRE_TICK_MAX;
            end
        end
        return ft;
    endfunction

endpackage

// ===== src/tpad_step.sv =====
// ---------------------------------------------------------------------------
// Phase-angle dimmer update logic
// Works out the next half-cycle state and the result word for one item.
// ---------------------------------------------------------------------------
module tpad_step (
    input  tpad_pkg::state_t                    state_i,
    input  logic                                req_type,
    input  logic [tpad_pkg::TS_BITS-1:0]        now_us,
    input  logic [tpad_pkg::DIM_BITS-1:0]       dim_level,
    input  logic [tpad_pkg::MIN_ZC_BITS-1:0]    min_gap_us,
    output tpad_pkg::state_t                    state_o,
    output tpad_pkg::result_t                   result_o
);

    logic [tpad_pkg::TS_BITS-1:0]   zc_diff;
    logic                           zc_pass;
    logic [tpad_pkg::TICK_BITS-1:0] tick_inc;
    logic [tpad_pkg::TICK_BITS-1:0] fire_at;
    logic [tpad_pkg::TICK_BITS:0]   pulse_end;
    logic                           accepted;

    // Interval since the last accepted crossing, modulo the timestamp width.
    assign zc_diff   = now_us - state_i.last_crossing_time;
    assign zc_pass   = (zc_diff >= tpad_pkg::TS_BITS'(min_gap_us));
    assign tick_inc  = state_i.tick_count + 1'b1;
    assign fire_at   = tpad_pkg::gate_tick(dim_level);
    assign pulse_end = {1'b0, fire_at} + {1'b0, tpad_pkg::PULSE_TICKS};

    // State update for a zero cross or a tick.
    always_comb begin
        state_o  = state_i;
        accepted = 1'b0;
        if (req_type == tpad_pkg::REQ_ZERO_CROSS) begin
            if (zc_pass) begin
                state_o.measured_half_cycle = tpad_pkg::HALF_BITS'(zc_diff);
                state_o.last_crossing_time  = now_us;
                state_o.tick_count          = '0;
                state_o.armed               = 1'b1;
                state_o.gate_level          = 1'b0;
                accepted                    = 1'b1;
            end
        end else if (state_i.armed) begin
            state_o.tick_count = tick_inc;
            if (tick_inc >= tpad_pkg::CUTOFF_TICK) begin
                state_o.armed = 1'b0;
            end
            if (tick_inc == fire_at) begin
                state_o.last_fire_time = tpad_pkg::FIRE_BITS'(
                    tpad_pkg::FIRE_BITS'(tick_inc) * tpad_pkg::TICK_US);
                state_o.gate_level     = 1'b1;
            end
            if ({1'b0, tick_inc} == pulse_end) begin
                state_o.gate_level = 1'b0;
            end
            if (tick_inc > tpad_pkg::TICK_HARD_LIMIT) begin
                state_o.armed = 1'b0;
            end
        end
    end

    // Result word reflects the state after the item.
    assign result_o.gate_on       = state_o.gate_level;
    assign result_o.zc_accepted   = accepted;
    assign result_o.half_cycle_us = state_o.measured_half_cycle;
    assign result_o.fire_time_us  = state_o.last_fire_time;

endmodule

// ===== src/triac_phase_angle_dimmer.sv =====
// ---------------------------------------------------------------------------
// Phase-angle triac dimmer
// Filters zero-cross events, counts 50 us ticks and drives the triac gate.
// ---------------------------------------------------------------------------
// Usage:
// Each input word is a zero-cross edge (s_tuser low, timestamp in s_tdata)
// or one 50 us timer tick (s_tuser high). Every input word yields exactly
// one output word on the m_ channel with the gate level, a flag for an
// accepted zero cross, the last half-cycle length and the last fire delay.
// A word passes through an input register and then a result register before
// its result is offered on the m_ channel. One word can be taken in every
// cycle while the receiver keeps m_tready high; the rate is one word per
// clock, set by the single update stage between the two registers.
// When the receiver holds m_tready low, the result register holds its word
// and the input register still takes one more word; after that s_tready
// falls until the result is taken.
// Reset (aresetn low at a clock edge) empties both registers, clears the
// half-cycle state with the gate off and disarmed, sets the brightness to
// zero and the minimum zero-cross interval to 8000 us.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data. The user
// must write it only while no word is in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
module triac_phase_angle_dimmer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [tpad_pkg::IN_DATA_BITS-1:0]     s_tdata,   // [31:0] now_us
    input  logic                                  s_tuser,   // [0] req_type
    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] gate_on, [1] zc_accepted, [33:2] half_cycle_us, [47:34] fire_time_us
    output logic [tpad_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    // Configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [tpad_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [tpad_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    logic                                in_valid_reg;
    logic                                in_type_reg;
    logic [tpad_pkg::TS_BITS-1:0]        in_now_reg;
    logic                                out_valid_reg;
    tpad_pkg::result_t                   out_reg;
    tpad_pkg::result_t                   result_next;
    tpad_pkg::state_t                    state_reg;
    tpad_pkg::state_t                    state_next;
    logic [tpad_pkg::DIM_BITS-1:0]       dim_level_reg;
    logic [tpad_pkg::MIN_ZC_BITS-1:0]    min_zc_reg;
    logic                                advance;
    logic                                s_accept;

    // Handshake: the update stage moves when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_level_reg <= '0;
            min_zc_reg    <= tpad_pkg::MIN_ZC_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tpad_pkg::CFG_DIM_LEVEL: dim_level_reg <= cfg_data[tpad_pkg::DIM_BITS-1:0];
                tpad_pkg::CFG_MIN_ZC:    min_zc_reg    <= cfg_data[tpad_pkg::MIN_ZC_BITS-1:0];
                default:                 ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_type_reg <= s_tuser;
            in_now_reg  <= s_tdata[tpad_pkg::TS_BITS-1:0];
        end
    end

    // Update logic for one word.
    tpad_step u_step (
        .state_i    (state_reg),
        .req_type   (in_type_reg),
        .now_us     (in_now_reg),
        .dim_level  (dim_level_reg),
        .min_gap_us (min_zc_reg),
        .state_o    (state_next),
        .result_o   (result_next)
    );

    // Half-cycle state, committed as each word leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.fire_time_us, out_reg.half_cycle_us,
                       out_reg.zc_accepted, out_reg.gate_on};

`ifndef NO_ASSERTIONS
    // The tick count never runs past the cutoff tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.tick_count <= tpad_pkg::CUTOFF_TICK)
        else $error("tick count beyond cutoff");

    // An accepted zero cross always leaves the gate off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.zc_accepted |-> !out_reg.gate_on)
        else $error("gate on after accepted zero cross");

    // Disarming only follows a tick word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(state_reg.armed) |-> $past(advance && (in_type_reg == tpad_pkg::REQ_TICK)))
        else $error("disarmed without a tick");

    // The input side stalls only when both registers hold words and m_tready is low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");
`endif

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// Testbench for the phase-angle triac dimmer
// Drives zero-cross and tick words into the dimmer, predicts each result word
// with a cycle-free model of the half-cycle state, and compares every field of
// every result word in order. A table of directed words comes first; it is
// followed by random half cycles under several settings and idling patterns.
// ---------------------------------------------------------------------------
module tb_top;
    import tpad_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    // Kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_TICKS,
        ROW_WRITE
    } row_kind_e;

    // One directed row: sel is the word kind, or the register index for a write
    typedef struct packed {
        row_kind_e   kind;
        logic        sel;
        logic [31:0] value;
        int          count;
        logic        typed;
        result_t     want;
    } row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Predicted dimmer state and settings
    logic [TS_BITS-1:0]     zc_last_time;
    logic [HALF_BITS-1:0]   zc_half;
    logic [TICK_BITS-1:0]   zc_ticks;
    logic                   zc_armed;
    logic                   zc_gate;
    logic [FIRE_BITS-1:0]   zc_fire;
    logic [DIM_BITS-1:0]    dim_cfg;
    logic [MIN_ZC_BITS-1:0] min_zc_cfg;

    result_t outstanding[$];
    result_t got_word;
    result_t want_word;
    int      mismatches     = 0;
    int      sent_words     = 0;
    int      cycles_run     = 0;
    int      send_idle_pct  = 19;
    int      recv_stall_pct = 57;

    // Directed words; typed results are the ones that follow directly from
    // the reset state and the timestamps chosen.
    row_t plan [25] = '{
        // tick while disarmed straight after reset
        '{ROW_WORD,  REQ_TICK,       32'd0,          0, 1'b1, '{14'd0, 32'd0, 1'b0, 1'b0}},
        // crossing too close to the reset timestamp
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'd100,        0, 1'b1, '{14'd0, 32'd0, 1'b0, 1'b0}},
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'hFFFF_FFFF,  0, 1'b1,
          '{14'd0, 32'hFFFF_FFFF, 1'b1, 1'b0}},
        // timestamp wraps: one short of the interval, then exactly on it
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'h0000_1F3E,  0, 1'b1,
          '{14'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'h0000_1F3F,  0, 1'b1, '{14'd0, 32'd8000, 1'b1, 1'b0}},
        '{ROW_WORD,  REQ_TICK,       32'hFFFF_FFFF,  0, 1'b1, '{14'd0, 32'd8000, 1'b0, 1'b0}},
        // zero brightness fires on the cutoff tick and the gate stays high
        '{ROW_TICKS, REQ_TICK,       32'd0,        176, 1'b0, '0},
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'h0001_0000,  0, 1'b1,
          '{14'd8750, 32'd57537, 1'b1, 1'b0}},
        // brightness written with junk in the upper bits
        '{ROW_WRITE, CFG_DIM_LEVEL,  32'h0000_FFE4,  0, 1'b0, '0},
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'h0002_0000,  0, 1'b1,
          '{14'd8750, 32'd65536, 1'b1, 1'b0}},
        '{ROW_TICKS, REQ_TICK,       32'd0,        131, 1'b0, '0},
        '{ROW_WRITE, CFG_DIM_LEVEL,  32'h0000_007F,  0, 1'b0, '0},
        '{ROW_WRITE, CFG_MIN_ZC,     32'h0000_0000,  0, 1'b0, '0},
        // no hold-off: a repeated timestamp is accepted with a zero interval
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'h0002_0000,  0, 1'b1, '{14'd6250, 32'd0, 1'b1, 1'b0}},
        '{ROW_TICKS, REQ_TICK,       32'd0,        120, 1'b0, '0},
        '{ROW_WRITE, CFG_MIN_ZC,     32'h0000_FFFF,  0, 1'b0, '0},
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'h0002_FFFE,  0, 1'b1, '{14'd5600, 32'd0, 1'b0, 1'b0}},
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'h0002_FFFF,  0, 1'b1,
          '{14'd5600, 32'd65535, 1'b1, 1'b0}},
        '{ROW_TICKS, REQ_TICK,       32'd0,         10, 1'b0, '0},
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'h0003_0000,  0, 1'b0, '0},
        '{ROW_TICKS, REQ_TICK,       32'd0,         10, 1'b0, '0},
        // fire tick close to the cutoff: disarmed before the pulse ends
        '{ROW_WRITE, CFG_DIM_LEVEL,  32'h0000_0006,  0, 1'b0, '0},
        '{ROW_WRITE, CFG_MIN_ZC,     32'h0000_1F40,  0, 1'b0, '0},
        '{ROW_WORD,  REQ_ZERO_CROSS, 32'h0004_0000,  0, 1'b0, '0},
        '{ROW_TICKS, REQ_TICK,       32'd0,        177, 1'b0, '0}
    };

    triac_phase_angle_dimmer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Tick on which the gate fires for a brightness setting.
    function automatic logic [TICK_BITS-1:0] gate_tick_for(input logic [DIM_BITS-1:0] dim);
        logic [TICK_BITS-1:0] drop;
        logic [TICK_BITS-1:0] tick;
        drop = TICK_BITS'(dim) >> 1;
        tick = (drop > FIRE_BASE_TICK) ? FIRE_TICK_MAX : FIRE_BASE_TICK - drop;
        if (tick > FIRE_TICK_MAX) begin
            tick = FIRE_TICK_MAX;
        end
        return tick;
    endfunction

    // Advances the predicted state by one word and returns its result word.
    function automatic result_t dimmer_step(input logic kind, input logic [TS_BITS-1:0] stamp);
        result_t              r;
        logic [TS_BITS-1:0]   gap;
        logic [TICK_BITS-1:0] fire_at;
        logic [31:0]          delay;
        r.zc_accepted = 1'b0;
        if (kind == REQ_ZERO_CROSS) begin
            gap = stamp - zc_last_time;
            if (gap >= TS_BITS'(min_zc_cfg)) begin
                zc_half       = gap;
                zc_last_time  = stamp;
                zc_ticks      = '0;
                zc_armed      = 1'b1;
                zc_gate       = 1'b0;
                r.zc_accepted = 1'b1;
            end
        end else if (zc_armed) begin
            fire_at  = gate_tick_for(dim_cfg);
            zc_ticks = zc_ticks + 8'd1;
            if (zc_ticks >= CUTOFF_TICK) begin
                zc_armed = 1'b0;
            end
            if (zc_ticks == fire_at) begin
                delay   = 32'(zc_ticks) * 32'(TICK_US);
                zc_fire = delay[FIRE_BITS-1:0];
                zc_gate = 1'b1;
            end
            // The pulse end is compared one bit wider so that it never wraps.
            if ({1'b0, zc_ticks} == {1'b0, fire_at} + 9'(PULSE_TICKS)) begin
                zc_gate = 1'b0;
            end
            if (zc_ticks > TICK_HARD_LIMIT) begin
                zc_armed = 1'b0;
            end
        end
        r.gate_on       = zc_gate;
        r.half_cycle_us = zc_half;
        r.fire_time_us  = zc_fire;
        return r;
    endfunction

    // Offers one word, with random idle cycles first, and queues its result.
    // Called and left at a falling edge.
    task automatic send_word(input logic kind, input logic [TS_BITS-1:0] stamp,
                             input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= stamp;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = dimmer_step(kind, stamp);
        outstanding.push_back(typed ? want : predicted);
        // Every word taken counts towards the total.
        sent_words++;
        @(negedge aclk);
    endtask

    // Holds the input back until every result word has been taken.
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        while (outstanding.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Writes one register; the enable is dropped again afterwards.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        if (idx == CFG_DIM_LEVEL) begin
            dim_cfg = data[DIM_BITS-1:0];
        end else begin
            min_zc_cfg = data[MIN_ZC_BITS-1:0];
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random traffic, mostly the start of half cycles, until the given
    // number of words has been sent.
    task automatic run_random(input int target);
        int                   first;
        int                   pick;
        int                   n_ticks;
        logic [TICK_BITS-1:0] fire_at;
        logic [TS_BITS-1:0]   gap;
        first = sent_words;
        while (sent_words - first < target) begin
            pick = $urandom_range(99);
            if (pick == 0) begin
                drain_wait();
            end else if (pick < 70) begin
                fire_at = gate_tick_for(dim_cfg);
                // Now and then an edge that lands inside the hold-off.
                if ($urandom_range(9) < 2 && min_zc_cfg != 0) begin
                    send_word(REQ_ZERO_CROSS, zc_last_time + TS_BITS'(min_zc_cfg)
                              - TS_BITS'($urandom_range(1, min_zc_cfg)), 1'b0, '0);
                end
                if ($urandom_range(9) < 8) begin
                    gap = TS_BITS'(min_zc_cfg) + TS_BITS'($urandom_range(0, 3000));
                end else begin
                    gap = $urandom;
                end
                send_word(REQ_ZERO_CROSS, zc_last_time + gap, 1'b0, '0);
                case ($urandom_range(2))
                    0: begin
                        n_ticks = $urandom_range(0, 200);
                    end
                    1: begin
                        n_ticks = int'(fire_at) + $urandom_range(0, 7);
                    end
                    default: begin
                        n_ticks = $urandom_range(168, 190);
                    end
                endcase
                for (int k = 0; k < n_ticks && sent_words - first < target; k++) begin
                    if ($urandom_range(49) == 0) begin
                        send_word(REQ_ZERO_CROSS, zc_last_time
                                  + TS_BITS'($urandom_range(0, min_zc_cfg)), 1'b0, '0);
                    end
                    send_word(REQ_TICK, $urandom, 1'b0, '0);
                end
            end else if (pick < 85) begin
                send_word(REQ_ZERO_CROSS, $urandom, 1'b0, '0);
            end else begin
                repeat ($urandom_range(1, 12)) send_word(REQ_TICK, $urandom, 1'b0, '0);
            end
        end
    endtask

    // The receiver stalls at random, decided at each falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each result word taken is compared with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got_word = result_t'(m_tdata);
            if (outstanding.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result word: gate %0b zc %0b half %0d fire %0d",
                             got_word.gate_on, got_word.zc_accepted,
                             got_word.half_cycle_us, got_word.fire_time_us);
                end
            end else begin
                want_word = outstanding.pop_front();
                if (got_word.gate_on !== want_word.gate_on
                        || got_word.zc_accepted !== want_word.zc_accepted
                        || got_word.half_cycle_us !== want_word.half_cycle_us
                        || got_word.fire_time_us !== want_word.fire_time_us) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        // Fields in the order gate, zc, half cycle, fire delay.
                        $display("mismatch: expected %0b/%0b/%0d/%0d got %0b/%0b/%0d/%0d",
                                 want_word.gate_on, want_word.zc_accepted,
                                 want_word.half_cycle_us, want_word.fire_time_us,
                                 got_word.gate_on, got_word.zc_accepted,
                                 got_word.half_cycle_us, got_word.fire_time_us);
                    end
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Reset, directed table, random phases and the final verdict.
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_ZERO_CROSS;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_DIM_LEVEL;
        cfg_data     = '0;
        zc_last_time = '0;
        zc_half      = '0;
        zc_ticks     = '0;
        zc_armed     = 1'b0;
        zc_gate      = 1'b0;
        zc_fire      = '0;
        dim_cfg      = '0;
        min_zc_cfg   = MIN_ZC_RESET;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        @(negedge aclk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE: begin
                    drain_wait();
                    write_reg(plan[i].sel, plan[i].value[CFG_DATA_BITS-1:0]);
                end
                ROW_TICKS: begin
                    repeat (plan[i].count) send_word(REQ_TICK, $urandom, 1'b0, '0);
                end
                default: begin
                    send_word(plan[i].sel, plan[i].value, plan[i].typed, plan[i].want);
                end
            endcase
        end

        // Two settings under each idling pattern.
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct  = (ph < 2) ? 19 : (ph < 4) ? 57 : 0;
            recv_stall_pct = (ph < 2) ? 57 : (ph < 4) ? 19 : 0;
            drain_wait();
            case ($urandom_range(3))
                0: begin
                    write_reg(CFG_DIM_LEVEL, {9'($urandom), 7'($urandom_range(0, 12))});
                end
                1: begin
                    write_reg(CFG_DIM_LEVEL, 16'($urandom));
                end
                2: begin
                    write_reg(CFG_DIM_LEVEL, {9'($urandom), 7'd100});
                end
                default: begin
                    write_reg(CFG_DIM_LEVEL, {9'($urandom), 7'd127});
                end
            endcase
            case ($urandom_range(3))
                0: begin
                    write_reg(CFG_MIN_ZC, 16'd0);
                end
                1: begin
                    write_reg(CFG_MIN_ZC, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_MIN_ZC, MIN_ZC_RESET);
                end
                default: begin
                    write_reg(CFG_MIN_ZC, 16'($urandom));
                end
            endcase
            run_random(35);
        end

        drain_wait();
        repeat (6) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
